/* rtl/selective_repeat_receiver_assert.svh */
// Assertion macros shared by the selective-repeat receiver modules.
`ifndef SELECTIVE_REPEAT_RECEIVER_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVER_ASSERT_SVH

// The condition must never hold at a clock edge outside reset.
`define SRR_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define SRR_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/srr_pkg.sv */
// Shared types and constants of the selective-repeat receiver.
`default_nettype none

package srr_pkg;

   localparam int CFG_W                = 6;
   localparam int WIN_DEFAULT          = 32;
   localparam int HEADER_BYTES_DEFAULT = 8;
   localparam logic [CFG_W-1:0] WIN_SIZE_RESET = 6'd8;

   localparam logic [1:0] KIND_DELIVER = 2'd0;
   localparam logic [1:0] KIND_ACK     = 2'd1;
   localparam logic [1:0] KIND_RELEASE = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_CLASSIFY,
      ST_BAD_ACK,
      ST_BAD_REL,
      ST_CK_REL,
      ST_SCAN,
      ST_BASE,
      ST_DUP_REL,
      ST_DRAIN_RD,
      ST_DRAIN_EMIT,
      ST_ACK
   } srr_state_type;

   typedef struct packed {
      logic write;
      logic pop;
   } srr_ring_cmd_type;

endpackage

`default_nettype wire

/* rtl/srr_slot_ring.sv */
// Slot ring of the receive window: filled flags, head pointer and slot memory.
`default_nettype none

module srr_slot_ring #(
   parameter int WIN = srr_pkg::WIN_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  srr_pkg::srr_ring_cmd_type cmd,
   input  logic [$clog2(WIN)-1:0]   off,
   input  logic [15:0]              wr_handle,
   input  logic [15:0]              wr_len,
   output logic                     probe_filled,
   output logic [15:0]              rd_handle,
   output logic [15:0]              rd_len
);

   localparam int IDX_W = $clog2(WIN);

   logic [IDX_W-1:0] head_ff, head_in;
   logic [WIN-1:0]   filled_ff, filled_in;
   logic [31:0]      mem [WIN];
   logic [31:0]      rd_data_ff;
   logic [IDX_W:0]   sum;
   logic [IDX_W-1:0] phys;

   // Offset from the window base folded onto the physical ring.
   assign sum  = {1'b0, head_ff} + {1'b0, off};
   assign phys = (sum >= (IDX_W+1)'(WIN)) ? IDX_W'(sum - (IDX_W+1)'(WIN)) : sum[IDX_W-1:0];

   assign probe_filled = filled_ff[phys];
   assign rd_handle    = rd_data_ff[31:16];
   assign rd_len       = rd_data_ff[15:0];

   always_comb begin
      filled_in = filled_ff;
      head_in   = head_ff;
      if (cmd.write) begin
         filled_in[phys] = 1'b1;
      end
      if (cmd.pop) begin
         filled_in[head_ff] = 1'b0;
         head_in = (head_ff == IDX_W'(WIN - 1)) ? '0 : head_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
         head_ff   <= '0;
      end else begin
         filled_ff <= filled_in;
         head_ff   <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem[phys] <= {wr_handle, wr_len};
      end
      if (cmd.pop) begin
         rd_data_ff <= mem[head_ff];
      end
   end

`include "selective_repeat_receiver_assert.svh"

   `SRR_ASSERT_IMPLIES(a_pop_filled, cmd.pop, filled_ff[head_ff], "pop of an empty slot")
   `SRR_ASSERT_IMPLIES(a_write_empty, cmd.write, !filled_ff[phys], "write over a filled slot")

endmodule

`default_nettype wire

/* rtl/selective_repeat_receiver.sv */
// Top level of the selective-repeat receiver: sequencer, shared adder and result register.
// Each segment is accepted in the idle state and passes the offset and classify states
// before its first result beat is loaded; a segment that fills the window base first
// scans the run of filled slots, advances the base and drains the run, one slot memory
// read per slot. A new segment is taken only back in idle, and output stalls hold the
// sequencer. Reset clears the base, the filled flags and the ring head and sets win_size
// to 8; slot memory is not cleared, a slot is only read once written.
`default_nettype none

module selective_repeat_receiver #(
   parameter int WIN          = srr_pkg::WIN_DEFAULT,
   parameter int HEADER_BYTES = srr_pkg::HEADER_BYTES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   // Segment beats.
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [63:0]              req_tdata,   // seq_num, buffer_handle, segment_length
   input  logic [1:0]               req_tuser,   // ident_is_data, checksum_good
   // Result beats.
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [95:0]              rsp_tdata,   // ack_seq, next_expected, out_handle,
                                                 // payload_length
   output logic [1:0]               rsp_tuser,   // kind
   output logic                     rsp_tlast,   // last
   // Window size register.
   input  logic                     csr_we,
   input  logic [srr_pkg::CFG_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(WIN);
   localparam int CNT_W = $clog2(WIN + 1);
   localparam int CFG_W = srr_pkg::CFG_W;

   srr_pkg::srr_state_type state_ff, state_in;

   logic [CFG_W-1:0] win_size_ff;
   logic [31:0]      base_ff, base_in;
   logic [CNT_W-1:0] run_ff, run_in;

   // Captured segment and intermediate results.
   logic [31:0] seq_ff;
   logic        is_data_ff;
   logic        ck_good_ff;
   logic [15:0] handle_ff;
   logic [15:0] len_ff;
   logic [31:0] diff_ff;
   logic [31:0] aux_ff;
   logic        dup_ff;

   // Result register.
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [1:0]  rsp_kind_ff;
   logic [31:0] rsp_ack_ff;
   logic [31:0] rsp_next_ff;
   logic [15:0] rsp_handle_ff;
   logic [15:0] rsp_plen_ff;
   logic        rsp_last_ff;

   // Sequencer outputs.
   logic        emit;
   logic [1:0]  o_kind;
   logic [31:0] o_ack;
   logic [15:0] o_handle;
   logic [15:0] o_plen;
   logic        o_last;
   srr_pkg::srr_ring_cmd_type ring_cmd;

   // Shared adder.
   logic [31:0] add_a, add_b, add_sum;
   logic        add_sub;

   logic [CFG_W-1:0] eff;
   logic             in_window;
   logic             diff_zero;
   logic             out_free;
   logic             deliver_ok;
   logic [IDX_W-1:0] ring_off;
   logic             probe_filled;
   logic [15:0]      rd_handle, rd_len;

   assign req_tready = (state_ff == srr_pkg::ST_IDLE);
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // The effective window is the smaller of the register and the ring depth.
   assign eff       = (win_size_ff < CFG_W'(WIN)) ? win_size_ff : CFG_W'(WIN);
   assign in_window = (diff_ff[31:CFG_W] == '0) && (diff_ff[CFG_W-1:0] < eff);
   assign diff_zero = (diff_ff == '0);

   // During the scan the ring is probed at the run count, otherwise at the segment offset.
   assign ring_off = (state_ff == srr_pkg::ST_SCAN) ? run_ff[IDX_W-1:0] : diff_ff[IDX_W-1:0];

   // One adder serves the window offset, base - 1, the base advance and the payload length.
   always_comb begin
      add_a   = base_ff;
      add_b   = '0;
      add_sub = 1'b0;
      unique case (state_ff)
         srr_pkg::ST_DIFF: begin
            add_a   = seq_ff;
            add_b   = base_ff;
            add_sub = 1'b1;
         end
         srr_pkg::ST_CLASSIFY: begin
            add_a   = base_ff;
            add_b   = 32'd1;
            add_sub = 1'b1;
         end
         srr_pkg::ST_BASE: begin
            add_a   = base_ff;
            add_b   = 32'(run_ff);
            add_sub = 1'b0;
         end
         srr_pkg::ST_DRAIN_EMIT: begin
            add_a   = {16'b0, rd_len};
            add_b   = 32'(HEADER_BYTES);
            add_sub = 1'b1;
         end
         default: begin
            add_a   = base_ff;
            add_b   = '0;
            add_sub = 1'b0;
         end
      endcase
      add_sum = add_a + (add_sub ? ~add_b : add_b) + {31'b0, add_sub};
   end

   // Both operands stay below 2^16, so a positive difference means a real payload.
   assign deliver_ok = (add_sum != '0) && !add_sum[31];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff) inside
         srr_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = srr_pkg::ST_DIFF;
         end
         srr_pkg::ST_DIFF: begin
            state_in = srr_pkg::ST_CLASSIFY;
         end
         srr_pkg::ST_CLASSIFY: begin
            if (!is_data_ff || !in_window) begin
               state_in = srr_pkg::ST_BAD_ACK;
            end else if (!ck_good_ff) begin
               state_in = srr_pkg::ST_CK_REL;
            end else if (diff_zero) begin
               state_in = srr_pkg::ST_SCAN;
            end else if (probe_filled) begin
               state_in = srr_pkg::ST_DUP_REL;
            end else begin
               state_in = srr_pkg::ST_ACK;
            end
         end
         srr_pkg::ST_BAD_ACK: begin
            if (out_free) state_in = srr_pkg::ST_BAD_REL;
         end
         srr_pkg::ST_BAD_REL, srr_pkg::ST_CK_REL, srr_pkg::ST_ACK: begin
            if (out_free) state_in = srr_pkg::ST_IDLE;
         end
         srr_pkg::ST_SCAN: begin
            if (!((run_ff < CNT_W'(WIN)) && probe_filled)) state_in = srr_pkg::ST_BASE;
         end
         srr_pkg::ST_BASE: begin
            state_in = dup_ff ? srr_pkg::ST_DUP_REL : srr_pkg::ST_DRAIN_RD;
         end
         srr_pkg::ST_DUP_REL: begin
            if (out_free) state_in = srr_pkg::ST_DRAIN_RD;
         end
         srr_pkg::ST_DRAIN_RD: begin
            state_in = (run_ff == '0) ? srr_pkg::ST_ACK : srr_pkg::ST_DRAIN_EMIT;
         end
         srr_pkg::ST_DRAIN_EMIT: begin
            if (out_free) state_in = srr_pkg::ST_DRAIN_RD;
         end
         default: begin
            state_in = srr_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs: result beats and ring commands.
   always_comb begin
      emit     = 1'b0;
      o_kind   = srr_pkg::KIND_ACK;
      o_ack    = '0;
      o_handle = '0;
      o_plen   = '0;
      o_last   = 1'b0;
      ring_cmd = '0;
      unique case (state_ff) inside
         srr_pkg::ST_CLASSIFY: begin
            ring_cmd.write = is_data_ff && in_window && ck_good_ff && !probe_filled;
         end
         srr_pkg::ST_BAD_ACK: begin
            emit   = out_free;
            o_kind = srr_pkg::KIND_ACK;
            o_ack  = aux_ff;
         end
         srr_pkg::ST_BAD_REL, srr_pkg::ST_CK_REL: begin
            emit     = out_free;
            o_kind   = srr_pkg::KIND_RELEASE;
            o_handle = handle_ff;
            o_last   = 1'b1;
         end
         srr_pkg::ST_DUP_REL: begin
            emit     = out_free;
            o_kind   = srr_pkg::KIND_RELEASE;
            o_handle = handle_ff;
         end
         srr_pkg::ST_DRAIN_RD: begin
            ring_cmd.pop = (run_ff != '0);
         end
         srr_pkg::ST_DRAIN_EMIT: begin
            emit     = out_free;
            o_handle = rd_handle;
            if (deliver_ok) begin
               o_kind = srr_pkg::KIND_DELIVER;
               o_plen = add_sum[15:0];
            end else begin
               o_kind = srr_pkg::KIND_RELEASE;
            end
         end
         srr_pkg::ST_ACK: begin
            emit   = out_free;
            o_kind = srr_pkg::KIND_ACK;
            o_ack  = seq_ff;
            o_last = 1'b1;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // Control register next values.
   always_comb begin
      base_in = base_ff;
      run_in  = run_ff;
      if (state_ff == srr_pkg::ST_CLASSIFY) begin
         run_in = '0;
      end
      if ((state_ff == srr_pkg::ST_SCAN) && (run_ff < CNT_W'(WIN)) && probe_filled) begin
         run_in = run_ff + CNT_W'(1);
      end
      if (ring_cmd.pop) begin
         run_in = run_ff - CNT_W'(1);
      end
      if (state_ff == srr_pkg::ST_BASE) begin
         base_in = add_sum;
      end
      rsp_tvalid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_tvalid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= srr_pkg::ST_IDLE;
         win_size_ff   <= srr_pkg::WIN_SIZE_RESET;
         base_ff       <= '0;
         run_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         base_ff       <= base_in;
         run_ff        <= run_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_we) begin
            win_size_ff <= csr_wdata;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if ((state_ff == srr_pkg::ST_IDLE) && req_tvalid) begin
         seq_ff     <= req_tdata[31:0];
         handle_ff  <= req_tdata[47:32];
         len_ff     <= req_tdata[63:48];
         is_data_ff <= req_tuser[0];
         ck_good_ff <= req_tuser[1];
      end
      if (state_ff == srr_pkg::ST_DIFF) begin
         diff_ff <= add_sum;
      end
      if (state_ff == srr_pkg::ST_CLASSIFY) begin
         aux_ff <= add_sum;
         dup_ff <= probe_filled;
      end
      // The base is final before the first beat of a segment is loaded.
      if (emit) begin
         rsp_kind_ff   <= o_kind;
         rsp_ack_ff    <= o_ack;
         rsp_next_ff   <= base_ff;
         rsp_handle_ff <= o_handle;
         rsp_plen_ff   <= o_plen;
         rsp_last_ff   <= o_last;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_plen_ff, rsp_handle_ff, rsp_next_ff, rsp_ack_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   srr_slot_ring #(
      .WIN (WIN)
   ) u_ring (
      .clock        (clock),
      .reset        (reset),
      .cmd          (ring_cmd),
      .off          (ring_off),
      .wr_handle    (handle_ff),
      .wr_len       (len_ff),
      .probe_filled (probe_filled),
      .rd_handle    (rd_handle),
      .rd_len       (rd_len)
   );

`include "selective_repeat_receiver_assert.svh"

   `SRR_ASSERT_NEVER(a_no_overwrite, emit && rsp_tvalid_ff && !rsp_tready, "result beat lost")
   `SRR_ASSERT_NEVER(a_run_bound, run_ff > CNT_W'(WIN), "run count beyond the ring depth")
   `SRR_ASSERT_NEXT(a_base_hold, state_ff != srr_pkg::ST_BASE, $stable(base_ff), "base moved")

endmodule

`default_nettype wire
